// ===== rtl/button_hold_event_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Button hold event classifier - assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_HOLD_EVENT_CLASSIFIER_ASSERT_SVH
`define BUTTON_HOLD_EVENT_CLASSIFIER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BHEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BHEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bhec_pkg.sv =====
// ----------------------------------------------------------------------------
// Button hold event classifier - package
// Widths, register indexes, event and hold level codes, shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package bhec_pkg;

  // Sizes
  localparam int NUM_BUTTONS  = 6;
  localparam int TIME_BITS    = 32;
  localparam int BTN_BITS     = $clog2(NUM_BUTTONS + 1);
  localparam int LEVELS_W     = 6;
  localparam int NOW_W        = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int CODE_W       = 3;

  // Buttons with auto-repeat
  localparam logic [BTN_BITS-1:0] UP_BUTTON   = BTN_BITS'(4);
  localparam logic [BTN_BITS-1:0] DOWN_BUTTON = BTN_BITS'(5);

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_SHORT_HOLD = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_HOLD  = 16'd1500;
  localparam logic [CFG_DATA_W-1:0] RST_VERY_HOLD  = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] RST_SUPER_HOLD = 16'd6000;
  localparam logic [CFG_DATA_W-1:0] RST_SLOW_REP   = 16'd125;
  localparam logic [CFG_DATA_W-1:0] RST_FAST_REP   = 16'd20;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE   = 16'd150;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SHORT_HOLD = 3'd0,
    CFG_LONG_HOLD  = 3'd1,
    CFG_VERY_HOLD  = 3'd2,
    CFG_SUPER_HOLD = 3'd3,
    CFG_SLOW_REP   = 3'd4,
    CFG_FAST_REP   = 3'd5,
    CFG_DEBOUNCE   = 3'd6,
    CFG_REPEAT_EN  = 3'd7
  } cfg_idx_e;

  // Request types
  typedef enum logic {
    REQ_POLL = 1'b0,
    REQ_STOP = 1'b1
  } req_e;

  // Event codes
  localparam logic [CODE_W-1:0] EVT_RELEASE = 3'd0;
  localparam logic [CODE_W-1:0] EVT_PRESS   = 3'd1;

  // Hold levels (threshold levels double as their event codes)
  localparam logic [CODE_W-1:0] LVL_NONE    = 3'd0;
  localparam logic [CODE_W-1:0] LVL_SHORT   = 3'd2;
  localparam logic [CODE_W-1:0] LVL_LONG    = 3'd3;
  localparam logic [CODE_W-1:0] LVL_VERY    = 3'd4;
  localparam logic [CODE_W-1:0] LVL_SUPER   = 3'd5;
  localparam logic [CODE_W-1:0] LVL_STOPPED = 3'd6;

  // Configuration register file
  typedef struct packed {
    logic [CFG_DATA_W-1:0] short_hold_ms;
    logic [CFG_DATA_W-1:0] long_hold_ms;
    logic [CFG_DATA_W-1:0] very_long_hold_ms;
    logic [CFG_DATA_W-1:0] super_long_hold_ms;
    logic [CFG_DATA_W-1:0] slow_repeat_ms;
    logic [CFG_DATA_W-1:0] fast_repeat_ms;
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic                  repeat_enable;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [CODE_W-1:0] button_index;
    logic [CODE_W-1:0] event_code;
    logic [CODE_W-1:0] prior_level;
    logic              last_of_run;
  } evt_t;

endpackage

`default_nettype wire

// ===== rtl/bhec_if.sv =====
// ----------------------------------------------------------------------------
// Button hold event classifier - channel interfaces
// Valid/ready channels for polls, events and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Poll / stop request channel
interface bhec_poll_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bhec_pkg::LEVELS_W-1:0] button_levels;
  logic [bhec_pkg::NOW_W-1:0]    now_ms;

  modport source (output valid, output req_type, output button_levels, output now_ms,
                  input ready);
  modport sink   (input valid, input req_type, input button_levels, input now_ms,
                  output ready);
endinterface

// Event result channel
interface bhec_event_if;
  logic                        valid;
  logic                        ready;
  logic [bhec_pkg::CODE_W-1:0] button_index;
  logic [bhec_pkg::CODE_W-1:0] event_code;
  logic [bhec_pkg::CODE_W-1:0] prior_level;
  logic                        last_of_run;

  modport source (output valid, output button_index, output event_code,
                  output prior_level, output last_of_run, input ready);
  modport sink   (input valid, input button_index, input event_code,
                  input prior_level, input last_of_run, output ready);
endinterface

// Configuration write channel
interface bhec_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bhec_pkg::CFG_IDX_BITS-1:0] index;
  logic [bhec_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/button_hold_event_classifier.sv =====
// ----------------------------------------------------------------------------
// Button hold event classifier - top level
// Turns polled button levels into press, release, hold and repeat events.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                        Notes
//  poll_i    in   req_type, button_levels, now_ms                poll or stop
//  event_o   out  button_index, event_code, prior_level, last    0..2 per poll
//  cfg_i     in   index, data                                    always ready
//
//  A poll is registered on transfer and fully classified in the next cycle,
//  then its 0..2 events move into a 2-entry result buffer at once.
//  The first event is valid after the poll passes from the input register
//  into the result buffer, and can transfer out from there.
//  One poll per cycle sustained while the buffer has room for its events;
//  a poll with two events leaves one at a time by the single-event-wide port.
//  The input register holds while the buffer lacks room for its events.
//  Reset: no owner, hold level none, times zero, registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_hold_event_classifier_assert.svh"

module button_hold_event_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bhec_poll_if.sink        poll_i,
  bhec_event_if.source     event_o,
  bhec_cfg_if.sink         cfg_i
);

  localparam int BB = bhec_pkg::BTN_BITS;
  localparam int TB = bhec_pkg::TIME_BITS;
  localparam int NB = bhec_pkg::NUM_BUTTONS;
  localparam int CW = bhec_pkg::CODE_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  bhec_pkg::cfg_t                    cfg_q;
  logic [bhec_pkg::CFG_DATA_W-1:0]   cfg_min1;

  assign cfg_i.ready = 1'b1;
  // zero intervals and thresholds read as one
  assign cfg_min1 = (cfg_i.data == '0) ? bhec_pkg::CFG_DATA_W'(1) : cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_hold_ms      <= bhec_pkg::RST_SHORT_HOLD;
      cfg_q.long_hold_ms       <= bhec_pkg::RST_LONG_HOLD;
      cfg_q.very_long_hold_ms  <= bhec_pkg::RST_VERY_HOLD;
      cfg_q.super_long_hold_ms <= bhec_pkg::RST_SUPER_HOLD;
      cfg_q.slow_repeat_ms     <= bhec_pkg::RST_SLOW_REP;
      cfg_q.fast_repeat_ms     <= bhec_pkg::RST_FAST_REP;
      cfg_q.debounce_ms        <= bhec_pkg::RST_DEBOUNCE;
      cfg_q.repeat_enable      <= 1'b1;
    end else if (cfg_i.valid) begin
      case (bhec_pkg::cfg_idx_e'(cfg_i.index))
        bhec_pkg::CFG_SHORT_HOLD: cfg_q.short_hold_ms      <= cfg_min1;
        bhec_pkg::CFG_LONG_HOLD:  cfg_q.long_hold_ms       <= cfg_min1;
        bhec_pkg::CFG_VERY_HOLD:  cfg_q.very_long_hold_ms  <= cfg_min1;
        bhec_pkg::CFG_SUPER_HOLD: cfg_q.super_long_hold_ms <= cfg_min1;
        bhec_pkg::CFG_SLOW_REP:   cfg_q.slow_repeat_ms     <= cfg_min1;
        bhec_pkg::CFG_FAST_REP:   cfg_q.fast_repeat_ms     <= cfg_min1;
        bhec_pkg::CFG_DEBOUNCE:   cfg_q.debounce_ms        <= cfg_i.data;
        bhec_pkg::CFG_REPEAT_EN:  cfg_q.repeat_enable      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  bhec_pkg::req_e      s1_req_q;
  logic [NB-1:0]       s1_levels_q;
  logic [TB-1:0]       s1_now_q;
  logic                s1_retire;
  logic                poll_xfer;

  assign poll_i.ready = !s1_valid_q || s1_retire;
  assign poll_xfer    = poll_i.valid && poll_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      s1_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_xfer) begin
      s1_req_q    <= bhec_pkg::req_e'(poll_i.req_type);
      s1_levels_q <= poll_i.button_levels[NB-1:0];
      s1_now_q    <= poll_i.now_ms[TB-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Hold state
  // --------------------------------------------------------------------------
  logic [BB-1:0] active_q, active_d;
  logic [CW-1:0] hold_level_q, hold_level_d;
  logic [TB-1:0] press_time_q, press_time_d;
  logic [TB-1:0] repeat_time_q, repeat_time_d;

  // --------------------------------------------------------------------------
  // Classification
  // --------------------------------------------------------------------------
  logic [BB-1:0]  own_idx;
  logic           owner_present;
  logic           owner_pressed;
  logic           hold_path;
  logic [TB-1:0]  since_press;
  logic [TB-1:0]  since_repeat;
  logic           bounce;
  logic           live;
  logic           hit_short, hit_long, hit_very, hit_super;
  logic           thr_fire;
  logic [CW-1:0]  thr_level;
  logic           short_fired;
  logic           is_updown;
  logic [bhec_pkg::CFG_DATA_W-1:0] gap;
  logic           rep_fire;
  logic           rel_fire;
  logic           prs_fire;
  logic [BB-1:0]  prs_idx;
  bhec_pkg::evt_t ev_a, ev_b;
  logic           ev_a_v, ev_b_v;
  logic [1:0]     n_events;

  assign own_idx       = active_q - BB'(1);
  assign owner_present = (active_q != '0);
  assign owner_pressed = owner_present && s1_levels_q[own_idx];
  assign hold_path     = owner_pressed;

  assign since_press  = s1_now_q - press_time_q;
  assign since_repeat = s1_now_q - repeat_time_q;
  assign bounce       = since_press < TB'(cfg_q.debounce_ms);
  assign live         = (s1_req_q == bhec_pkg::REQ_POLL) && !bounce;

  // hold thresholds, highest newly passed wins
  assign hit_super = since_press >= TB'(cfg_q.super_long_hold_ms);
  assign hit_very  = since_press >= TB'(cfg_q.very_long_hold_ms);
  assign hit_long  = since_press >= TB'(cfg_q.long_hold_ms);
  assign hit_short = since_press >= TB'(cfg_q.short_hold_ms);

  always_comb begin
    thr_fire  = 1'b0;
    thr_level = hold_level_q;
    if (hit_super && hold_level_q < bhec_pkg::LVL_SUPER) begin
      thr_fire  = 1'b1;
      thr_level = bhec_pkg::LVL_SUPER;
    end else if (hit_very && hold_level_q < bhec_pkg::LVL_VERY) begin
      thr_fire  = 1'b1;
      thr_level = bhec_pkg::LVL_VERY;
    end else if (hit_long && hold_level_q < bhec_pkg::LVL_LONG) begin
      thr_fire  = 1'b1;
      thr_level = bhec_pkg::LVL_LONG;
    end else if (hit_short && hold_level_q < bhec_pkg::LVL_SHORT) begin
      thr_fire  = 1'b1;
      thr_level = bhec_pkg::LVL_SHORT;
    end
  end

  // auto-repeat on up/down; a short hold restarts the repeat clock itself
  assign short_fired = thr_fire && (thr_level == bhec_pkg::LVL_SHORT);
  assign is_updown   = (own_idx == bhec_pkg::UP_BUTTON) || (own_idx == bhec_pkg::DOWN_BUTTON);
  assign gap         = (thr_level >= bhec_pkg::LVL_LONG) ? cfg_q.fast_repeat_ms
                                                         : cfg_q.slow_repeat_ms;
  assign rep_fire    = is_updown && cfg_q.repeat_enable && (thr_level >= bhec_pkg::LVL_SHORT)
                       && !short_fired && (since_repeat >= TB'(gap));

  // release of the owner, silent when stopped
  assign rel_fire = owner_present && !owner_pressed
                    && (hold_level_q != bhec_pkg::LVL_STOPPED);

  // lowest pressed button after the owner (or any, with no owner)
  always_comb begin
    prs_fire = 1'b0;
    prs_idx  = '0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (s1_levels_q[i] && !owner_pressed && (!owner_present || BB'(i) > own_idx)) begin
        prs_fire = 1'b1;
        prs_idx  = BB'(i);
      end
    end
  end

  // pack up to two events in scan order
  always_comb begin
    if (hold_path) begin
      ev_a = thr_fire ? '{own_idx, thr_level, hold_level_q, 1'b0}
                      : '{own_idx, bhec_pkg::EVT_PRESS, thr_level, 1'b0};
      ev_b   = '{own_idx, bhec_pkg::EVT_PRESS, thr_level, 1'b1};
      ev_a_v = live && (thr_fire || rep_fire);
      ev_b_v = live && thr_fire && rep_fire;
    end else begin
      ev_a = rel_fire ? '{own_idx, bhec_pkg::EVT_RELEASE, hold_level_q, 1'b0}
                      : '{prs_idx, bhec_pkg::EVT_PRESS, bhec_pkg::LVL_NONE, 1'b0};
      ev_b   = '{prs_idx, bhec_pkg::EVT_PRESS, bhec_pkg::LVL_NONE, 1'b1};
      ev_a_v = live && (rel_fire || prs_fire);
      ev_b_v = live && rel_fire && prs_fire;
    end
    ev_a.last_of_run = !ev_b_v;
    n_events = ev_b_v ? 2'd2 : (ev_a_v ? 2'd1 : 2'd0);
  end

  // next hold state
  always_comb begin
    active_d      = active_q;
    hold_level_d  = hold_level_q;
    press_time_d  = press_time_q;
    repeat_time_d = repeat_time_q;
    if (s1_req_q == bhec_pkg::REQ_STOP) begin
      hold_level_d = bhec_pkg::LVL_STOPPED;
    end else if (!bounce) begin
      if (hold_path) begin
        hold_level_d = thr_level;
        if (short_fired || rep_fire) begin
          repeat_time_d = s1_now_q;
        end
      end else begin
        if (owner_present) begin
          active_d     = '0;
          hold_level_d = bhec_pkg::LVL_NONE;
        end
        if (prs_fire) begin
          active_d     = prs_idx + BB'(1);
          hold_level_d = bhec_pkg::LVL_NONE;
          press_time_d = s1_now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= '0;
      hold_level_q  <= bhec_pkg::LVL_NONE;
      press_time_q  <= '0;
      repeat_time_q <= '0;
    end else if (s1_retire) begin
      active_q      <= active_d;
      hold_level_q  <= hold_level_d;
      press_time_q  <= press_time_d;
      repeat_time_q <= repeat_time_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer, two entries
  // --------------------------------------------------------------------------
  bhec_pkg::evt_t fifo_q [2];
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           wr_ptr;
  logic           pop;
  logic [1:0]     free_slots;
  logic           push_a, push_b;

  assign pop        = event_o.valid && event_o.ready;
  assign free_slots = 2'd2 - cnt_q + {1'b0, pop};
  assign s1_retire  = s1_valid_q && (n_events <= free_slots);
  assign wr_ptr     = rd_ptr_q ^ cnt_q[0];
  assign push_a     = s1_retire && ev_a_v;
  assign push_b     = s1_retire && ev_b_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_q ^ pop;
      cnt_q    <= cnt_q - {1'b0, pop} + (s1_retire ? n_events : 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      fifo_q[wr_ptr] <= ev_a;
    end
    if (push_b) begin
      fifo_q[~wr_ptr] <= ev_b;
    end
  end

  // output drive
  assign event_o.valid        = (cnt_q != 2'd0);
  assign event_o.button_index = fifo_q[rd_ptr_q].button_index;
  assign event_o.event_code   = fifo_q[rd_ptr_q].event_code;
  assign event_o.prior_level  = fifo_q[rd_ptr_q].prior_level;
  assign event_o.last_of_run  = fifo_q[rd_ptr_q].last_of_run;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BHEC_ASSERT_NEXT(a_stop_sets_stopped, s1_retire && (s1_req_q == bhec_pkg::REQ_STOP), hold_level_q == bhec_pkg::LVL_STOPPED, "stop request did not mark hold stopped")
  `BHEC_ASSERT_NOW(a_owner_in_range, 1'b1, active_q <= BB'(NB), "owner index out of range")
  `BHEC_ASSERT_NOW(a_idle_level, active_q == '0, (hold_level_q == bhec_pkg::LVL_NONE) || (hold_level_q == bhec_pkg::LVL_STOPPED), "hold level set with no owner")
  `BHEC_ASSERT_NOW(a_buffer_bound, 1'b1, cnt_q <= 2'd2, "result buffer overfilled")

endmodule

`default_nettype wire
